[rtl/polygon_centroid_3d_assert.svh]
// Assertion macros of the polygon centroid design.
`ifndef POLYGON_CENTROID_3D_ASSERT_SVH
`define POLYGON_CENTROID_3D_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PC3D_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pc3d: same-cycle check failed");

// Next-cycle implication.
`define PC3D_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pc3d: next-cycle check failed");

`endif

[rtl/pc3d_pkg.sv]
// Shared widths, types and codes of the polygon centroid design.
package pc3d_pkg;

	localparam int CW      = 16;              // coordinate width at the ports
	localparam int CNT_W   = 9;               // vertex count, up to 511 vertices
	localparam int CROSS_W = 2 * CW + 1;      // one edge cross term
	localparam int PSUM_W  = CW + 1;          // sum of two coordinates
	localparam int MTERM_W = PSUM_W + CROSS_W;
	localparam int AREA_W  = CROSS_W + CNT_W; // twice the projected area, signed integer, Q42.0
	localparam int MOM_W   = MTERM_W + CNT_W; // first moment sum, signed integer, Q59.0
	localparam int SUM_W   = CW + CNT_W;      // coordinate sum
	localparam int REF_W   = 32;
	localparam int D3_W    = AREA_W + 1;      // magnitude of three times an area
	localparam int DD_W    = MOM_W + 2;       // dividend of the rounding divider
	localparam int DV_W    = AREA_W + 3;      // divisor of the rounding divider
	localparam int TERM_W  = 62;              // one signed projection term
	localparam int SEL_W   = TERM_W + 1;      // sum of two terms
	localparam int OUT_W   = 16;
	localparam int SCALE_W = 14;
	localparam int FLAT_SCALE = 10000;        // area is flat below ref_area / 10000
	localparam int NTERM   = 7;               // six projection terms and the mean
	localparam int IDX_W   = $clog2(NTERM + 1);

	localparam logic signed [TERM_W-1:0] BIG_TERM = TERM_W'(64'sd1 <<< 60);
	localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] SAT_MIN = -16'sh8000;

	typedef logic signed [CW-1:0]     coord_t;
	typedef logic signed [AREA_W-1:0] area_t;
	typedef logic signed [MOM_W-1:0]  mom_t;
	typedef logic signed [SUM_W-1:0]  csum_t;

	typedef enum logic [1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_t;

	// Everything the back end needs to finish one polygon.
	typedef struct packed {
		area_t [2:0]      area;     // xy, xz, yz
		mom_t [5:0]       mom;      // xy:x, xy:y, xz:x, xz:z, yz:y, yz:z
		csum_t [2:0]      csum;
		logic [CNT_W-1:0] count;
		logic             overflow;
		logic [REF_W-1:0] ref_area;
	} job_t;

endpackage

[rtl/pc3d_front.sv]
// Vertex intake, edge arithmetic pipeline and per-polygon accumulators.
module pc3d_front #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         coord_x,
	input  logic [15:0]         coord_y,
	input  logic [15:0]         coord_z,
	input  logic [31:0]         ref_area,
	input  logic                last_vertex,
	output logic                push_valid,
	input  logic                push_ready,
	output pc3d_pkg::job_t      push_job
);
	import pc3d_pkg::*;

	localparam int SHIFT = CW - COORD_WIDTH;

	typedef enum logic [2:0] {
		F_RUN   = 3'b001,
		F_WRAP  = 3'b010,
		F_DRAIN = 3'b100
	} fstate_t;

	fstate_t state_q;

	coord_t vin [3];
	coord_t first_q [3];
	coord_t prev_q [3];
	logic [CNT_W-1:0] count_q;
	logic ovf_q;
	logic [REF_W-1:0] ref_area_q;
	area_t area_q [3];
	mom_t mom_q [6];
	csum_t csum_q [3];

	logic accept, room, pipe_empty, push_fire;
	logic iss_valid;
	coord_t iss_a [3];
	coord_t iss_b [3];

	logic v_s1, v_s2, v_s3, v_s4;
	coord_t a_s1 [3];
	coord_t b_s1 [3];
	logic signed [2*CW-1:0] prod_s2 [6];
	logic signed [PSUM_W-1:0] psum_s2 [3];
	logic signed [PSUM_W-1:0] psum_s3 [3];
	logic signed [CROSS_W-1:0] cross_s3 [3];
	logic signed [CROSS_W-1:0] cross_s4 [3];
	logic signed [MTERM_W-1:0] mterm_s4 [6];

	function automatic coord_t sext(logic [CW-1:0] raw);
		logic [CW-1:0] sh;
		sh = raw << SHIFT;
		return coord_t'($signed(sh) >>> SHIFT);
	endfunction

	assign vin[0] = sext(coord_x);
	assign vin[1] = sext(coord_y);
	assign vin[2] = sext(coord_z);

	assign in_ready   = (state_q == F_RUN);
	assign accept     = in_valid && in_ready;
	assign room       = (count_q < CNT_W'(MAX_VERTICES));
	assign pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign push_valid = (state_q == F_DRAIN) && pipe_empty;
	assign push_fire  = push_valid && push_ready;

	// A new edge enters the pipeline for every held vertex after the first,
	// and once more, unless the polygon overflowed, for the closing edge from the last vertex back to the first.
	always_comb begin
		iss_valid = 1'b0;
		iss_a = prev_q;
		iss_b = vin;
		if (accept && room && (count_q != '0)) begin
			iss_valid = 1'b1;
		end else if ((state_q == F_WRAP) && !ovf_q) begin
			iss_valid = 1'b1;
			iss_b = first_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= iss_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= iss_a;
		b_s1 <= iss_b;
		prod_s2[0] <= a_s1[0] * b_s1[1];
		prod_s2[1] <= b_s1[0] * a_s1[1];
		prod_s2[2] <= a_s1[0] * b_s1[2];
		prod_s2[3] <= b_s1[0] * a_s1[2];
		prod_s2[4] <= a_s1[1] * b_s1[2];
		prod_s2[5] <= b_s1[1] * a_s1[2];
		for (int k = 0; k < 3; k++) begin
			psum_s2[k] <= PSUM_W'(a_s1[k]) + PSUM_W'(b_s1[k]);
			cross_s3[k] <= CROSS_W'(prod_s2[2*k]) - CROSS_W'(prod_s2[2*k+1]);
			psum_s3[k] <= psum_s2[k];
			cross_s4[k] <= cross_s3[k];
		end
		mterm_s4[0] <= psum_s3[0] * cross_s3[0];
		mterm_s4[1] <= psum_s3[1] * cross_s3[0];
		mterm_s4[2] <= psum_s3[0] * cross_s3[1];
		mterm_s4[3] <= psum_s3[2] * cross_s3[1];
		mterm_s4[4] <= psum_s3[1] * cross_s3[2];
		mterm_s4[5] <= psum_s3[2] * cross_s3[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_RUN;
			count_q <= '0;
			ovf_q <= 1'b0;
			ref_area_q <= '0;
			for (int k = 0; k < 3; k++) begin
				first_q[k] <= '0;
				prev_q[k] <= '0;
				area_q[k] <= '0;
				csum_q[k] <= '0;
			end
			for (int k = 0; k < 6; k++) begin
				mom_q[k] <= '0;
			end
		end else begin
			if (v_s4) begin
				for (int k = 0; k < 3; k++) begin
					area_q[k] <= area_q[k] + AREA_W'(cross_s4[k]);
				end
				for (int k = 0; k < 6; k++) begin
					mom_q[k] <= mom_q[k] + MOM_W'(mterm_s4[k]);
				end
			end
			unique case (state_q)
				F_RUN: begin
					if (accept) begin
						if (room) begin
							if (count_q == '0) begin
								first_q <= vin;
							end
							prev_q <= vin;
							for (int k = 0; k < 3; k++) begin
								csum_q[k] <= csum_q[k] + SUM_W'(vin[k]);
							end
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_vertex) begin
							ref_area_q <= ref_area;
							state_q <= F_WRAP;
						end
					end
				end
				F_WRAP: begin
					state_q <= F_DRAIN;
				end
				F_DRAIN: begin
					if (push_fire) begin
						count_q <= '0;
						ovf_q <= 1'b0;
						for (int k = 0; k < 3; k++) begin
							first_q[k] <= '0;
							prev_q[k] <= '0;
							area_q[k] <= '0;
							csum_q[k] <= '0;
						end
						for (int k = 0; k < 6; k++) begin
							mom_q[k] <= '0;
						end
						state_q <= F_RUN;
					end
				end
				default: begin
					state_q <= F_RUN;
				end
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			push_job.area[k] = area_q[k];
			push_job.csum[k] = csum_q[k];
		end
		for (int k = 0; k < 6; k++) begin
			push_job.mom[k] = mom_q[k];
		end
		push_job.count = count_q;
		push_job.overflow = ovf_q;
		push_job.ref_area = ref_area_q;
	end

endmodule

[rtl/pc3d_queue.sv]
// Two-entry queue of finished polygon sums between the front and back ends.
module pc3d_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  pc3d_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output pc3d_pkg::job_t pop_job
);
	import pc3d_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);

	job_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [OCC_W-1:0] occ_q;
	logic do_push, do_pop;

	assign push_ready = (occ_q != OCC_W'(DEPTH));
	assign pop_valid  = (occ_q != '0);
	assign pop_job    = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			occ_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (do_pop && !do_push) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

endmodule

[rtl/pc3d_div.sv]
// Restoring divider, one quotient bit per cycle.
module pc3d_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pc3d_pkg::DD_W-1:0] dividend,
	input  logic [pc3d_pkg::DV_W-1:0] divisor,
	output logic                      busy,
	output logic                      done,
	output logic [pc3d_pkg::DD_W-1:0] quotient
);
	import pc3d_pkg::*;

	localparam int IT_W = $clog2(DD_W + 1);

	logic [DV_W-1:0] dvs_q, rem_q;
	logic [DD_W-1:0] quo_q;
	logic [IT_W-1:0] it_q;
	logic busy_q, done_q;
	logic [DV_W:0] trial;
	logic ge;

	assign trial    = {rem_q, quo_q[DD_W-1]};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DV_W'(trial - {1'b0, dvs_q}) : trial[DV_W-1:0];
			quo_q <= {quo_q[DD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q <= '0;
		end else begin
			// The final step raises done for exactly one cycle.
			done_q <= !start && busy_q && (it_q == IT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				it_q <= IT_W'(DD_W);
			end else if (busy_q) begin
				it_q <= it_q - IT_W'(1);
				if (it_q == IT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

[rtl/pc3d_back.sv]
// Flatness test, projection choice, term divisions and the result register.
module pc3d_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  pc3d_pkg::job_t                   pop_job,
	output logic                             div_start,
	output logic [pc3d_pkg::DD_W-1:0]        div_dividend,
	output logic [pc3d_pkg::DV_W-1:0]        div_divisor,
	input  logic                             div_done,
	input  logic [pc3d_pkg::DD_W-1:0]        div_quotient,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [pc3d_pkg::OUT_W-1:0] centroid_x,
	output logic signed [pc3d_pkg::OUT_W-1:0] centroid_y,
	output logic signed [pc3d_pkg::OUT_W-1:0] centroid_z,
	output logic [1:0]                       mean_axis,
	output logic                             divide_fault,
	output logic                             count_overflow
);
	import pc3d_pkg::*;

	localparam int PROD_W = AREA_W + SCALE_W;
	localparam logic [IDX_W-1:0] MEAN_IDX = IDX_W'(NTERM - 1);

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_MAG  = 7'b0000010,
		B_FLAT = 7'b0000100,
		B_PLAN = 7'b0001000,
		B_NEXT = 7'b0010000,
		B_WAIT = 7'b0100000,
		B_COMB = 7'b1000000
	} bstate_t;

	// Which projections feed the three coordinates.
	typedef enum logic [2:0] {
		M_YZ    = 3'd0,
		M_XZ    = 3'd1,
		M_XZ_YZ = 3'd2,
		M_XY    = 3'd3,
		M_XY_YZ = 3'd4,
		M_XY_XZ = 3'd5,
		M_ALL   = 3'd6
	} mode_t;

	bstate_t state_q;
	job_t job_q;
	logic [AREA_W-1:0] amag_q [3];
	logic [D3_W-1:0] dmag_q [3];
	logic [2:0] flat_q;
	mode_t mode_q;
	axis_t axis_q;
	logic [NTERM-1:0] need_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [TERM_W-1:0] term_q [NTERM];
	logic fault_q, neg_q;

	logic out_valid_q;
	logic signed [OUT_W-1:0] cx_q, cy_q, cz_q;
	logic [1:0] axis_out_q;
	logic fault_out_q, ovf_out_q;

	logic [1:0] pl, ai;
	logic [2:0] mi;
	mom_t mom_sel;
	csum_t sum_sel;
	logic [MOM_W-1:0] mom_mag;
	logic [SUM_W-1:0] sum_mag;
	logic term_neg, mean_neg, dzero;
	logic is_mean, out_free;
	logic [PROD_W-1:0] scaled [3];
	logic signed [SEL_W-1:0] c0, c1, c2;

	function automatic logic signed [SEL_W-1:0] avg2(logic signed [TERM_W-1:0] a,
			logic signed [TERM_W-1:0] b);
		logic signed [SEL_W-1:0] s;
		logic [SEL_W-1:0] m, q;
		s = SEL_W'(a) + SEL_W'(b);
		m = (s < 0) ? SEL_W'(-s) : SEL_W'(s);
		q = (m + SEL_W'(1)) >> 1;
		return (s < 0) ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [SEL_W-1:0] one(logic signed [TERM_W-1:0] a);
		return SEL_W'(a);
	endfunction

	function automatic logic signed [OUT_W-1:0] sat(logic signed [SEL_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SEL_W'(SAT_MAX)) begin
			r = SAT_MAX;
		end else if (v < SEL_W'(SAT_MIN)) begin
			r = SAT_MIN;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

	assign pop_ready = (state_q == B_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign is_mean   = (idx_q == MEAN_IDX);

	// Operand selection for the term or mean being worked on.
	always_comb begin
		pl = (idx_q[2:1] == 2'd3) ? 2'd0 : idx_q[2:1];
		mi = (idx_q < 3'(MEAN_IDX)) ? idx_q[2:0] : 3'd0;
		ai = (axis_q == AXIS_NONE) ? 2'd0 : 2'(axis_q) - 2'd1;
		mom_sel = $signed(job_q.mom[mi]);
		sum_sel = $signed(job_q.csum[ai]);
		mom_mag = (mom_sel < 0) ? MOM_W'(-mom_sel) : MOM_W'(mom_sel);
		sum_mag = (sum_sel < 0) ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
		term_neg = (mom_sel < 0) != ($signed(job_q.area[pl]) < 0);
		mean_neg = (sum_sel < 0);
		dzero = (dmag_q[pl] == '0);
		if (is_mean) begin
			div_dividend = DD_W'({sum_mag, 1'b0}) + DD_W'(job_q.count);
			div_divisor = DV_W'({job_q.count, 1'b0});
		end else begin
			div_dividend = DD_W'({mom_mag, 1'b0}) + DD_W'(dmag_q[pl]);
			div_divisor = DV_W'({dmag_q[pl], 1'b0});
		end
		div_start = (state_q == B_NEXT) && (idx_q != IDX_W'(NTERM)) && need_q[idx_q]
			&& (is_mean || !dzero);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			scaled[k] = PROD_W'(amag_q[k]) * PROD_W'(FLAT_SCALE);
		end
	end

	always_comb begin
		unique case (mode_q)
			M_YZ: begin
				c0 = one(term_q[6]); c1 = one(term_q[4]); c2 = one(term_q[5]);
			end
			M_XZ: begin
				c0 = one(term_q[2]); c1 = one(term_q[6]); c2 = one(term_q[3]);
			end
			M_XZ_YZ: begin
				c0 = one(term_q[2]); c1 = one(term_q[4]); c2 = one(term_q[5]);
			end
			M_XY: begin
				c0 = one(term_q[0]); c1 = one(term_q[1]); c2 = one(term_q[6]);
			end
			M_XY_YZ: begin
				c0 = one(term_q[0]); c1 = one(term_q[1]); c2 = one(term_q[5]);
			end
			M_XY_XZ: begin
				c0 = one(term_q[0]); c1 = one(term_q[1]); c2 = one(term_q[3]);
			end
			M_ALL: begin
				c0 = avg2(term_q[0], term_q[2]);
				c1 = avg2(term_q[1], term_q[4]);
				c2 = avg2(term_q[3], term_q[5]);
			end
			default: begin
				c0 = '0; c1 = '0; c2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					job_q <= pop_job;
				end
			end
			B_MAG: begin
				for (int k = 0; k < 3; k++) begin
					amag_q[k] <= ($signed(job_q.area[k]) < 0) ?
						AREA_W'(-$signed(job_q.area[k])) : AREA_W'(job_q.area[k]);
				end
			end
			B_FLAT: begin
				for (int k = 0; k < 3; k++) begin
					flat_q[k] <= scaled[k] < PROD_W'(job_q.ref_area);
					dmag_q[k] <= D3_W'(amag_q[k]) + D3_W'({amag_q[k], 1'b0});
				end
			end
			B_NEXT: begin
				neg_q <= is_mean ? mean_neg : term_neg;
				if ((idx_q != IDX_W'(NTERM)) && need_q[idx_q] && !is_mean && dzero) begin
					term_q[idx_q] <= (mom_sel > 0) ? BIG_TERM :
						((mom_sel < 0) ? -BIG_TERM : '0);
				end
			end
			B_WAIT: begin
				if (div_done) begin
					term_q[idx_q] <= neg_q ? -TERM_W'(div_quotient) : TERM_W'(div_quotient);
				end
			end
			B_COMB: begin
				if (out_free) begin
					if (job_q.overflow) begin
						cx_q <= SAT_MAX;
						cy_q <= SAT_MAX;
						cz_q <= SAT_MAX;
						axis_out_q <= AXIS_NONE;
						fault_out_q <= 1'b0;
						ovf_out_q <= 1'b1;
					end else begin
						cx_q <= sat(c0);
						cy_q <= sat(c1);
						cz_q <= sat(c2);
						axis_out_q <= axis_q;
						fault_out_q <= fault_q;
						ovf_out_q <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control sequencer: the flatness pattern picks the mode and the set of divisions,
	// which are then walked in index order; an overflowed polygon goes to the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			mode_q <= M_ALL;
			axis_q <= AXIS_NONE;
			need_q <= '0;
			idx_q <= '0;
			fault_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one being taken in the same cycle.
			if ((state_q == B_COMB) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						state_q <= B_MAG;
					end
				end
				B_MAG: begin
					state_q <= B_FLAT;
				end
				B_FLAT: begin
					state_q <= B_PLAN;
				end
				B_PLAN: begin
					idx_q <= '0;
					fault_q <= 1'b0;
					if (job_q.overflow) begin
						state_q <= B_COMB;
					end else begin
						state_q <= B_NEXT;
						priority if (flat_q[0] && flat_q[1]) begin
							mode_q <= M_YZ; axis_q <= AXIS_X; need_q <= 7'b1110000;
						end else if (flat_q[0] && flat_q[2]) begin
							mode_q <= M_XZ; axis_q <= AXIS_Y; need_q <= 7'b1001100;
						end else if (flat_q[0]) begin
							mode_q <= M_XZ_YZ; axis_q <= AXIS_NONE; need_q <= 7'b0110100;
						end else if (flat_q[1] && flat_q[2]) begin
							mode_q <= M_XY; axis_q <= AXIS_Z; need_q <= 7'b1000011;
						end else if (flat_q[1]) begin
							mode_q <= M_XY_YZ; axis_q <= AXIS_NONE; need_q <= 7'b0100011;
						end else if (flat_q[2]) begin
							mode_q <= M_XY_XZ; axis_q <= AXIS_NONE; need_q <= 7'b0001011;
						end else begin
							mode_q <= M_ALL; axis_q <= AXIS_NONE; need_q <= 7'b0111111;
						end
					end
				end
				B_NEXT: begin
					if (idx_q == IDX_W'(NTERM)) begin
						state_q <= B_COMB;
					end else if (!need_q[idx_q]) begin
						idx_q <= idx_q + IDX_W'(1);
					end else if (div_start) begin
						state_q <= B_WAIT;
					end else begin
						fault_q <= 1'b1;
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				B_WAIT: begin
					if (div_done) begin
						idx_q <= idx_q + IDX_W'(1);
						state_q <= B_NEXT;
					end
				end
				B_COMB: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign centroid_x     = cx_q;
	assign centroid_y     = cy_q;
	assign centroid_z     = cz_q;
	assign mean_axis      = axis_out_q;
	assign divide_fault   = fault_out_q;
	assign count_overflow = ovf_out_q;

endmodule

[rtl/polygon_centroid_3d.sv]
// Top level of the streaming 3D polygon centroid block.
//
// Usage: vertices of one closed polygon arrive as beats on the input channel
// (in_valid / in_ready), one vertex per beat, last_vertex set on the final one;
// ref_area is sampled with that final beat. One result beat per polygon leaves
// on the output channel (out_valid / out_ready).
// Throughput: the front end takes one vertex per cycle while its intake is open.
// After a last vertex it closes the intake for the closing edge, the drain of
// the four-stage edge pipeline and the hand-off into the two-entry queue.
// Sequence: the back end runs the flatness test in B_MAG, B_FLAT and B_PLAN,
// then visits each of the seven term slots in B_NEXT and runs a rounded
// division for each slot it needs: three when a projection is flat, six when
// none is, fewer when a divisor area is zero. An overflowed polygon runs no
// division. Each division runs through the 61-step restoring divider, and the
// two-entry queue lets the front end go on taking polygons meanwhile.
// Reset: clears all sums and counts, empties the queue, drops out_valid.
// Stall: when the receiver holds out_ready low, the result stays in the
// output register, the back end waits there, the queue fills, and finally
// in_ready drops at the end of the next polygon.
module polygon_centroid_3d #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic signed [15:0] coord_z,
	input  logic [31:0]        ref_area,
	input  logic               last_vertex,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] centroid_x,
	output logic signed [15:0] centroid_y,
	output logic signed [15:0] centroid_z,
	output logic [1:0]         mean_axis,
	output logic               divide_fault,
	output logic               count_overflow
);
	import pc3d_pkg::*;

	`include "polygon_centroid_3d_assert.svh"

	// Front end to queue.
	logic push_valid, push_ready;
	job_t push_job;

	// Queue to back end.
	logic pop_valid, pop_ready;
	job_t pop_job;

	// Back end to the divider.
	logic div_start, div_busy, div_done;
	logic [DD_W-1:0] div_dividend, div_quotient;
	logic [DV_W-1:0] div_divisor;

	// The front end sign-extends each coordinate, runs every edge through the
	// multiply pipeline and keeps the area, moment and coordinate sums.
	pc3d_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.ref_area    (ref_area),
		.last_vertex (last_vertex),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_job    (push_job)
	);

	pc3d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// The back end decides which projections are flat, runs only the divisions
	// the chosen projections need, and holds the result until it is taken.
	pc3d_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_job        (pop_job),
		.div_start      (div_start),
		.div_dividend   (div_dividend),
		.div_divisor    (div_divisor),
		.div_done       (div_done),
		.div_quotient   (div_quotient),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.centroid_x     (centroid_x),
		.centroid_y     (centroid_y),
		.centroid_z     (centroid_z),
		.mean_axis      (mean_axis),
		.divide_fault   (divide_fault),
		.count_overflow (count_overflow)
	);

	pc3d_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// The divider is only started when it is free.
	`PC3D_ASSERT_NOW(a_div_start_idle, div_start, !div_busy)

	// After the last vertex of a polygon the intake closes for the closing edge.
	`PC3D_ASSERT_NEXT(a_intake_closes, in_valid && in_ready && last_vertex, !in_ready)

	// An overflowed polygon reports no mean axis, no fault and saturated x.
	`PC3D_ASSERT_NOW(a_overflow_result, out_valid && count_overflow,
		(mean_axis == AXIS_NONE) && !divide_fault && (centroid_x == SAT_MAX))

endmodule

[test/tb_top.sv]
// Self-checking testbench for the streaming 3D polygon centroid block.
`timescale 1ns / 100ps

// Running polygon state and the expected result beats, checked in order.
class centroid_scoreboard;
	typedef struct {
		logic signed [15:0] cx, cy, cz;
		logic [1:0] axis;
		logic fault, ovf;
	} centroid_res_t;

	longint first_v[3], prev_v[3], area_sum[3], mom_sum[6], coord_sum[3];
	int unsigned vcount;
	bit ovf_seen;
	bit fault_acc;
	centroid_res_t pending_q[$];
	int unsigned err_count;

	function void clear_polygon();
		for (int k = 0; k < 3; k++) begin
			first_v[k] = 0;
			prev_v[k] = 0;
			area_sum[k] = 0;
			coord_sum[k] = 0;
		end
		for (int k = 0; k < 6; k++) mom_sum[k] = 0;
		vcount = 0;
		ovf_seen = 0;
	endfunction

	function new();
		clear_polygon();
		err_count = 0;
	endfunction

	function longint abs64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Rounded division, ties away from zero.
	function longint round_div(longint n, longint d);
		longint q;
		q = (2 * abs64(n) + abs64(d)) / (2 * abs64(d));
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function longint proj_term(longint num, longint area);
		longint d;
		d = 3 * area;
		if (d == 0) begin
			fault_acc = 1;
			return (num > 0) ? (64'sd1 <<< 60) : ((num < 0) ? -(64'sd1 <<< 60) : 0);
		end
		return round_div(num, d);
	endfunction

	function logic signed [15:0] sat16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return -16'sh8000;
		return v[15:0];
	endfunction

	function void add_edge(longint a[3], longint b[3]);
		longint cxy, cxz, cyz;
		cxy = a[0] * b[1] - b[0] * a[1];
		cxz = a[0] * b[2] - b[0] * a[2];
		cyz = a[1] * b[2] - b[1] * a[2];
		area_sum[0] += cxy;
		area_sum[1] += cxz;
		area_sum[2] += cyz;
		mom_sum[0] += (a[0] + b[0]) * cxy;
		mom_sum[1] += (a[1] + b[1]) * cxy;
		mom_sum[2] += (a[0] + b[0]) * cxz;
		mom_sum[3] += (a[2] + b[2]) * cxz;
		mom_sum[4] += (a[1] + b[1]) * cyz;
		mom_sum[5] += (a[2] + b[2]) * cyz;
	endfunction

	// Note one accepted vertex beat; a last vertex queues the expected centroid.
	function void note_vertex(logic signed [15:0] x, y, z, logic [31:0] refa, logic last);
		longint v[3], c[3], r;
		bit fxy, fxz, fyz;
		logic [1:0] axis;
		centroid_res_t res;
		v[0] = x;
		v[1] = y;
		v[2] = z;
		if (vcount >= 64) ovf_seen = 1;
		else begin
			if (vcount > 0) add_edge(prev_v, v);
			else first_v = v;
			prev_v = v;
			for (int k = 0; k < 3; k++) coord_sum[k] += v[k];
			vcount++;
		end
		if (!last) return;
		if (ovf_seen) begin
			res = '{16'sh7fff, 16'sh7fff, 16'sh7fff, pc3d_pkg::AXIS_NONE, 1'b0, 1'b1};
			pending_q = {pending_q, res};
			clear_polygon();
			return;
		end
		add_edge(prev_v, first_v);
		r = refa;
		fxy = abs64(area_sum[0]) * 10000 < r;
		fxz = abs64(area_sum[1]) * 10000 < r;
		fyz = abs64(area_sum[2]) * 10000 < r;
		fault_acc = 0;
		axis = pc3d_pkg::AXIS_NONE;
		c = '{0, 0, 0};
		if (fxy) begin
			if (fxz) begin
				c[1] = proj_term(mom_sum[4], area_sum[2]);
				c[2] = proj_term(mom_sum[5], area_sum[2]);
				axis = pc3d_pkg::AXIS_X;
			end else if (fyz) begin
				c[0] = proj_term(mom_sum[2], area_sum[1]);
				c[2] = proj_term(mom_sum[3], area_sum[1]);
				axis = pc3d_pkg::AXIS_Y;
			end else begin
				c[0] = proj_term(mom_sum[2], area_sum[1]);
				c[1] = proj_term(mom_sum[4], area_sum[2]);
				c[2] = proj_term(mom_sum[5], area_sum[2]);
			end
		end else if (fxz) begin
			c[0] = proj_term(mom_sum[0], area_sum[0]);
			c[1] = proj_term(mom_sum[1], area_sum[0]);
			if (fyz) axis = pc3d_pkg::AXIS_Z;
			else c[2] = proj_term(mom_sum[5], area_sum[2]);
		end else if (fyz) begin
			c[0] = proj_term(mom_sum[0], area_sum[0]);
			c[1] = proj_term(mom_sum[1], area_sum[0]);
			c[2] = proj_term(mom_sum[3], area_sum[1]);
		end else begin
			c[0] = round_div(proj_term(mom_sum[0], area_sum[0])
				+ proj_term(mom_sum[2], area_sum[1]), 2);
			c[1] = round_div(proj_term(mom_sum[1], area_sum[0])
				+ proj_term(mom_sum[4], area_sum[2]), 2);
			c[2] = round_div(proj_term(mom_sum[3], area_sum[1])
				+ proj_term(mom_sum[5], area_sum[2]), 2);
		end
		if (axis != pc3d_pkg::AXIS_NONE)
			c[axis - 1] = round_div(coord_sum[axis - 1], longint'(vcount));
		res = '{sat16(c[0]), sat16(c[1]), sat16(c[2]), axis, fault_acc, 1'b0};
		pending_q = {pending_q, res};
		clear_polygon();
	endfunction

	task report_mismatch(string what, longint got, longint want);
		$display("tb_top: mismatch on %s: got %0d, expected %0d", what, got, want);
		err_count++;
	endtask

	// Compare one accepted result beat with the oldest expected centroid.
	task check_result(logic signed [15:0] cx, cy, cz, logic [1:0] axis, logic fault, ovf);
		centroid_res_t e;
		if (pending_q.size() == 0) begin
			report_mismatch("unexpected result beat", 1, 0);
			return;
		end
		e = pending_q.pop_front();
		if (cx !== e.cx) report_mismatch("centroid_x", cx, e.cx);
		if (cy !== e.cy) report_mismatch("centroid_y", cy, e.cy);
		if (cz !== e.cz) report_mismatch("centroid_z", cz, e.cz);
		if (axis !== e.axis) report_mismatch("mean_axis", axis, e.axis);
		if (fault !== e.fault) report_mismatch("divide_fault", fault, e.fault);
		if (ovf !== e.ovf) report_mismatch("count_overflow", ovf, e.ovf);
	endtask
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic signed [15:0] coord_x = 0, coord_y = 0, coord_z = 0;
	logic [31:0] ref_area = 0;
	logic last_vertex = 0;
	logic out_valid, out_ready = 0;
	logic signed [15:0] centroid_x, centroid_y, centroid_z;
	logic [1:0] mean_axis;
	logic divide_fault, count_overflow;

	centroid_scoreboard sb = new();

	// Idle control: both sides go quiet about 8% of the time, except during a
	// calm window where neither idles. hold_off forces a long receiver stall.
	bit calm = 0;
	bit hold_off = 0;
	int unsigned idle_cycles = 0;
	int unsigned vertex_beats = 0;
	localparam int unsigned WATCHDOG_LIMIT = 20000;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	polygon_centroid_3d DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.ref_area(ref_area), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.centroid_x(centroid_x), .centroid_y(centroid_y), .centroid_z(centroid_z),
		.mean_axis(mean_axis), .divide_fault(divide_fault),
		.count_overflow(count_overflow)
	);

	// Sample both channels at the rising edge. Accepted vertices feed the
	// predictor; accepted results are checked. The watchdog counts cycles
	// with no beat on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_vertex(coord_x, coord_y, coord_z, ref_area, last_vertex);
				vertex_beats++;
			end
			if (out_valid && out_ready)
				sb.check_result(centroid_x, centroid_y, centroid_z, mean_axis,
					divide_fault, count_overflow);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: watchdog expired with %0d results pending",
					sb.pending_q.size());
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// The receiver changes out_ready on the falling edge only.
	always @(negedge clk) begin
		if (hold_off) out_ready <= 0;
		else out_ready <= calm || ($urandom_range(99) >= 8);
	end

	// Offer one vertex beat and hold it until accepted. Gaps happen before
	// the beat is raised, so valid never drops while a beat is waiting.
	task send_vertex(logic signed [15:0] x, y, z, logic [31:0] refa, logic last);
		while (!calm && $urandom_range(99) < 8) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		ref_area <= refa;
		last_vertex <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task finish_send();
		in_valid <= 0;
		@(negedge clk);
	endtask

	function logic signed [15:0] rand_coord(int unsigned span);
		if (span >= 65535) return 16'($urandom());
		return 16'($signed($urandom_range(2 * span)) - $signed(span));
	endfunction

	// Send one random polygon of n vertices at the given coordinate span.
	task send_polygon(int unsigned n, int unsigned span, logic [31:0] refa);
		for (int unsigned i = 0; i < n; i++)
			send_vertex(rand_coord(span), rand_coord(span), rand_coord(span), refa,
				i == n - 1);
	endtask

	// Planar polygon: one coordinate fixed, so at least two projections go flat.
	task send_flat_polygon(int unsigned n, int unsigned span, int flat_axis);
		logic signed [15:0] v[3];
		logic signed [15:0] fixed_val;
		fixed_val = rand_coord(span);
		for (int unsigned i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++) v[k] = rand_coord(span);
			v[flat_axis] = fixed_val;
			send_vertex(v[0], v[1], v[2], $urandom_range(1, 100000), i == n - 1);
		end
	endtask

	task wait_drained();
		while (sb.pending_q.size() != 0) @(negedge clk);
	endtask

	task pick_ref(output logic [31:0] refa);
		case ($urandom_range(3))
			0: refa = 0;
			1: refa = $urandom();
			default: refa = $urandom_range(0, 1 << 20);
		endcase
	endtask

	initial begin
		logic [31:0] refa;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part. A triangle in the xy plane and one in the yz plane, extremes of
		// the coordinate range, single and two vertex polygons (zero areas), a collinear
		// set, and the largest reference area on two of the polygons.
		calm = 1;
		send_vertex(0, 0, 0, 0, 1);
		send_vertex(16'sh0100, 16'sh0200, 16'sh0300, 1, 1);
		send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0);
		send_vertex(-16'sh8000, 16'sh7fff, -16'sh8000, 0, 0);
		send_vertex(16'sh7fff, -16'sh8000, 16'sh0000, 32'hffffffff, 1);
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(16'sh0100, 0, 0, 0, 0);
		send_vertex(0, 16'sh0100, 0, 100, 1);
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(0, 16'sh0100, 0, 0, 0);
		send_vertex(0, 0, 16'sh0100, 100, 1);
		send_vertex(16'sh0100, 16'sh0100, 16'sh0100, 0, 0);
		send_vertex(16'sh0200, 16'sh0200, 16'sh0200, 0, 0);
		send_vertex(16'sh0300, 16'sh0300, 16'sh0300, 0, 1);
		send_vertex(-16'sh8000, -16'sh8000, -16'sh8000, 0, 0);
		send_vertex(16'sh1000, -16'sh0800, 16'sh0400, 0, 1);
		send_vertex(16'sh0100, 16'sh0200, 16'sh0300, 32'hffffffff, 0);
		send_vertex(16'sh0400, -16'sh0500, 16'sh0600, 32'hffffffff, 0);
		send_vertex(-16'sh0700, 16'sh0800, 16'sh0900, 32'hffffffff, 1);
		calm = 0;

		// Vertex overflow: more than the maximum count in one polygon.
		send_polygon(70, 2000, 0);
		send_polygon(65, 100, 5);

		// Sender pause until every expected result has come back.
		finish_send();
		wait_drained();

		// Long receiver stall while the sender keeps offering polygons.
		fork
			begin
				hold_off = 1;
				repeat (3000) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 8; i++) send_polygon($urandom_range(3, 6), 1000, 0);
		join

		// Random part: mostly small polygons, flat ones mixed in, a few large.
		while (vertex_beats < 620) begin
			calm = (vertex_beats > 300 && vertex_beats < 380);
			pick_ref(refa);
			case ($urandom_range(9))
				0: send_flat_polygon($urandom_range(3, 6), 4000, $urandom_range(2));
				1: send_polygon($urandom_range(1, 2), 65535, refa);
				2: send_polygon($urandom_range(20, 64), 65535, refa);
				3: send_polygon($urandom_range(3, 8), 65535, refa);
				default: send_polygon($urandom_range(3, 8), $urandom_range(1, 3000), refa);
			endcase
		end
		calm = 0;
		finish_send();

		wait_drained();
		repeat (500) @(negedge clk);
		if (sb.err_count == 0 && sb.pending_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
